/* hdl/upq_pkg.sv */
// Shared types, widths and codes for the unsorted priority queue.
// Used by the channel interfaces, the controller and the top level.
package upq_pkg;

  // Store geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int DATA_W        = 32;
  localparam int PRIO_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 7;
  localparam int WORD_W        = DATA_W + PRIO_W;

  // Function codes
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Data returned by extract on an empty queue
  localparam logic signed [DATA_W-1:0] EMPTY_DATA = '1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  // Request to the entry store: one write and one read port
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // Result of one item
  typedef struct packed {
    data_t                      out_data;
    logic [STATUS_W-1:0]        status;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } result_t;

endpackage

/* hdl/upq_if.sv */
// Valid/ready channel interfaces for the queue's item and result streams.
// Depends on upq_pkg for the payload types.
interface upq_in_if;
  logic          valid;
  logic          ready;
  logic          func;
  upq_pkg::data_t data;
  upq_pkg::prio_t priority_req;

  modport source (output valid, output func, output data, output priority_req,
                  input ready);
  modport sink   (input valid, input func, input data, input priority_req,
                  output ready);
endinterface

interface upq_out_if;
  logic                                   valid;
  logic                                   ready;
  upq_pkg::data_t                         out_data;
  logic [upq_pkg::STATUS_W-1:0]           status;
  logic [upq_pkg::ENTRY_COUNT_W-1:0]      entry_count;

  modport source (output valid, output out_data, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input out_data, input status, input entry_count,
                  output ready);
endinterface

/* hdl/upq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
module upq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/upq_ctrl.sv */
// Sequencer of the queue: insert, scan for the best entry, compact the store.
// Depends on upq_pkg; drives the entry store through a ram_req_t bundle.
module upq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  // item side
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  upq_pkg::data_t                in_data,
  input  upq_pkg::prio_t                in_prio,
  // result side
  output logic                          res_valid,
  input  logic                          res_ready,
  output upq_pkg::result_t              res,
  // entry store
  output upq_pkg::ram_req_t             ram_req,
  input  logic [upq_pkg::WORD_W-1:0]    ram_rdata
);

  localparam int IDX_W = upq_pkg::IDX_W;
  localparam int CNT_W = upq_pkg::CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              ptr_r, ptr_nxt;
  logic                          issuing_r, issuing_nxt;
  logic                          rvalid_r, rvalid_nxt;
  logic [IDX_W-1:0]              rq_addr_r, rq_addr_nxt;
  logic                          best_valid_r, best_valid_nxt;
  logic [IDX_W-1:0]              best_idx_r, best_idx_nxt;
  upq_pkg::prio_t                best_prio_r, best_prio_nxt;
  upq_pkg::data_t                best_data_r, best_data_nxt;
  upq_pkg::data_t                res_data_r, res_data_nxt;
  logic [upq_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;

  upq_pkg::prio_t                rd_prio;
  upq_pkg::data_t                rd_data;
  logic                          cand_better;
  logic [CNT_W-1:0]              shift_start;

  assign rd_prio = ram_rdata[upq_pkg::WORD_W-1:upq_pkg::DATA_W];
  assign rd_data = ram_rdata[upq_pkg::DATA_W-1:0];

  // Strict greater-than keeps the newest entry among equal priorities
  assign cand_better = !best_valid_r || (rd_prio > best_prio_r);
  assign shift_start = CNT_W'(cand_better ? rq_addr_r : best_idx_r) + CNT_W'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.out_data    = res_data_r;
  assign res.status      = res_status_r;
  assign res.entry_count = upq_pkg::ENTRY_COUNT_W'(count_r);

  // Next-state and datapath control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    issuing_nxt    = issuing_r;
    rvalid_nxt     = 1'b0;
    rq_addr_nxt    = rq_addr_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_data_nxt  = best_data_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = count_r[IDX_W-1:0];
    ram_req.wdata = {in_prio, in_data};
    ram_req.raddr = ptr_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DONE;
          if (in_func == upq_pkg::FUNC_INSERT) begin
            res_data_nxt = '0;
            if (count_r >= CNT_W'(upq_pkg::CAPACITY)) begin
              res_status_nxt = upq_pkg::ST_FULL;
            end else begin
              // append as the newest entry
              ram_req.we     = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              res_status_nxt = upq_pkg::ST_OK;
            end
          end else if (count_r == '0) begin
            res_data_nxt   = upq_pkg::EMPTY_DATA;
            res_status_nxt = upq_pkg::ST_EMPTY;
          end else begin
            // start scan at the newest entry
            state_nxt      = S_SCAN;
            ptr_nxt        = count_r - CNT_W'(1);
            issuing_nxt    = 1'b1;
            best_valid_nxt = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // issue reads from newest down to oldest
        if (issuing_r) begin
          rvalid_nxt  = 1'b1;
          rq_addr_nxt = ptr_r[IDX_W-1:0];
          if (ptr_r == '0) begin
            issuing_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - CNT_W'(1);
          end
        end
        // compare returned entry against the best so far
        if (rvalid_r) begin
          best_valid_nxt = 1'b1;
          if (cand_better) begin
            best_idx_nxt  = rq_addr_r;
            best_prio_nxt = rd_prio;
            best_data_nxt = rd_data;
          end
          if (rq_addr_r == '0) begin
            // scan complete: close the gap behind the best entry
            state_nxt   = S_SHIFT;
            ptr_nxt     = shift_start;
            issuing_nxt = (shift_start < count_r);
          end
        end
      end

      S_SHIFT: begin
        // read each younger entry and write it one place down
        if (issuing_r) begin
          rvalid_nxt  = 1'b1;
          rq_addr_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt     = ptr_r + CNT_W'(1);
          issuing_nxt = ((ptr_r + CNT_W'(1)) < count_r);
        end
        if (rvalid_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = rq_addr_r - IDX_W'(1);
          ram_req.wdata = ram_rdata;
        end
        if (!issuing_r && !rvalid_r) begin
          count_nxt      = count_r - CNT_W'(1);
          res_data_nxt   = best_data_r;
          res_status_nxt = upq_pkg::ST_OK;
          state_nxt      = S_DONE;
        end
      end

      S_DONE: begin
        // hold result until the output stage takes it
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      issuing_r <= 1'b0;
      rvalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      issuing_r <= issuing_nxt;
      rvalid_r  <= rvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    rq_addr_r    <= rq_addr_nxt;
    best_valid_r <= best_valid_nxt;
    best_idx_r   <= best_idx_nxt;
    best_prio_r  <= best_prio_nxt;
    best_data_r  <= best_data_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule

/* hdl/unsorted_priority_queue_core.sv */
// Bounded priority queue held as an unsorted list in insertion order. One item
// is worked on at a time and in_ch.ready is high only while the sequencer is
// idle. The time an extract takes is set by the single read port of the
// entry store, which serves first the newest-to-oldest scan and then the
// compaction of younger entries. A result sits in an output register, so the
// next item is taken while that result still waits for its transfer. The store
// needs no clearing after reset.
//
// Depends on upq_pkg, upq_if, upq_ram and upq_ctrl.
module unsorted_priority_queue_core (
  input  logic     clk,
  input  logic     rst_n,
  upq_in_if.sink   in_ch,
  upq_out_if.source out_ch
);

  upq_pkg::ram_req_t               ram_req;
  logic [upq_pkg::WORD_W-1:0]      ram_rdata;
  logic                            res_valid;
  logic                            res_ready;
  upq_pkg::result_t                res;

  logic                            out_valid_r;
  upq_pkg::result_t                out_res_r;

  // Sequencer
  upq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .in_data   (in_ch.data),
    .in_prio   (in_ch.priority_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Entry store: {priority, data} per entry
  upq_ram #(
    .WIDTH (upq_pkg::WORD_W),
    .DEPTH (upq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_data    = out_res_r.out_data;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.entry_count = out_res_r.entry_count;

endmodule

/* tb/upq_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the unsorted priority queue core: watches both channels,
// predicts every result from a shadow copy of the queue and compares field by field.
// Depends on upq_pkg and the channel interfaces in upq_if.
module upq_result_checker (
  input  logic clk,
  input  logic rst_n,
  upq_in_if    in_mon,
  upq_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  // Shadow of the entry store, index 0 oldest
  upq_pkg::data_t   shadow_data[$];
  upq_pkg::prio_t   shadow_prio[$];
  // Results owed by the core, oldest first
  upq_pkg::result_t pending_results[$];
  int               mismatches = 0;

  // Apply one item to the shadow queue and return the result it must produce
  function automatic upq_pkg::result_t apply_queue_op(input logic func,
                                                      input upq_pkg::data_t data,
                                                      input upq_pkg::prio_t prio);
    upq_pkg::result_t res;
    int               best;
    res.out_data = '0;
    res.status   = upq_pkg::ST_OK;
    if (func == upq_pkg::FUNC_INSERT) begin
      if (shadow_data.size() >= upq_pkg::CAPACITY) begin
        res.status = upq_pkg::ST_FULL;
      end else begin
        shadow_data.push_back(data);
        shadow_prio.push_back(prio);
      end
    end else if (shadow_data.size() == 0) begin
      res.out_data = upq_pkg::EMPTY_DATA;
      res.status   = upq_pkg::ST_EMPTY;
    end else begin
      // scan newest to oldest; strict greater-than lets the newest of a tie win
      best = shadow_data.size() - 1;
      for (int i = shadow_data.size() - 2; i >= 0; i--) begin
        if (shadow_prio[i] > shadow_prio[best]) best = i;
      end
      res.out_data = shadow_data[best];
      shadow_data.delete(best);
      shadow_prio.delete(best);
    end
    res.entry_count = upq_pkg::ENTRY_COUNT_W'(shadow_data.size());
    return res;
  endfunction

  always @(posedge clk) begin : watch
    upq_pkg::result_t want;
    if (!rst_n) begin
      shadow_data.delete();
      shadow_prio.delete();
      pending_results.delete();
    end else begin
      // predict on every item transfer
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_queue_op(in_mon.func, in_mon.data,
                                                 in_mon.priority_req));
      end
      // compare every result transfer with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no item outstanding: out_data %0d status %0d",
                 out_mon.out_data, out_mon.status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_mon.out_data !== want.out_data) begin
            $error("out_data: expected %0d, got %0d", want.out_data, out_mon.out_data);
            mismatches++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            mismatches++;
          end
          if (out_mon.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_mon.entry_count);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= pending_results.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Top of the unsorted priority queue testbench: clock, reset, item stimulus,
// result back-pressure, watchdog and verdict. Depends on upq_pkg, upq_if,
// unsorted_priority_queue_core and upq_result_checker.
module tb;

  localparam int             ITEMS_PER_PHASE = 360;
  localparam int             WATCHDOG_LIMIT  = 4000;
  localparam int             TAIL_CYCLES     = 2 * upq_pkg::CAPACITY + 16;
  localparam upq_pkg::data_t DATA_MAX        = 32'sh7FFF_FFFF;
  localparam upq_pkg::data_t DATA_MIN        = 32'sh8000_0000;
  localparam upq_pkg::prio_t PRIO_MAX        = 32'sh7FFF_FFFF;
  localparam upq_pkg::prio_t PRIO_MIN        = 32'sh8000_0000;
  localparam int             BURST_FILL      = 0;
  localparam int             BURST_DRAIN     = 1;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   idle_cycles    = 0;

  upq_in_if  in_ch ();
  upq_out_if out_ch ();

  unsorted_priority_queue_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  upq_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one item, after a random gap, and hold it until its transfer
  task automatic send_item(input logic func, input upq_pkg::data_t data,
                           input upq_pkg::prio_t prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= func;
    in_ch.data         <= data;
    in_ch.priority_req <= prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic upq_pkg::data_t pick_data();
    case ($urandom_range(7))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      default: return $urandom();
    endcase
  endfunction

  // Favour a narrow band so that ties are frequent
  function automatic upq_pkg::prio_t pick_priority();
    case ($urandom_range(9))
      0:          return PRIO_MAX;
      1:          return PRIO_MIN;
      2, 3, 4, 5: return upq_pkg::prio_t'(int'($urandom_range(6)) - 3);
      default:    return $urandom();
    endcase
  endfunction

  // Extremes, ties, signed order and both empty cases
  task automatic run_directed();
    send_item(upq_pkg::FUNC_EXTRACT, pick_data(), pick_priority());
    send_item(upq_pkg::FUNC_INSERT, DATA_MAX, 32'sd5);
    send_item(upq_pkg::FUNC_INSERT, DATA_MIN, 32'sd5);
    send_item(upq_pkg::FUNC_INSERT, 32'sd0, PRIO_MAX);
    send_item(upq_pkg::FUNC_INSERT, -32'sd1, PRIO_MIN);
    send_item(upq_pkg::FUNC_INSERT, 32'sh5555_5555, -32'sd1);
    send_item(upq_pkg::FUNC_INSERT, 32'shAAAA_AAAA, 32'sd0);
    send_item(upq_pkg::FUNC_INSERT, 32'sd1, PRIO_MAX);
    for (int n = 0; n < 8; n++) begin
      send_item(upq_pkg::FUNC_EXTRACT, pick_data(), pick_priority());
    end
  endtask

  // Bursts that fill, drain or churn the queue, so full and empty both recur
  task automatic run_phase(input int idle_pct, input int stall_pct);
    int issued;
    int burst_len;
    int insert_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    issued         = 0;
    while (issued < ITEMS_PER_PHASE) begin
      burst_len = $urandom_range(90, 20);
      case ($urandom_range(2))
        BURST_FILL:  insert_pct = 90;
        BURST_DRAIN: insert_pct = 10;
        default:     insert_pct = 55;
      endcase
      for (int n = 0; n < burst_len && issued < ITEMS_PER_PHASE; n++) begin
        send_item(($urandom_range(99) < insert_pct) ? upq_pkg::FUNC_INSERT
                                                    : upq_pkg::FUNC_EXTRACT,
                  pick_data(), pick_priority());
        issued++;
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= upq_pkg::FUNC_INSERT;
    in_ch.data         <= '0;
    in_ch.priority_req <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_phase(0, 0);
    run_phase(73, 0);
    run_phase(0, 73);
    run_phase(15, 15);

    // drop valid, then let the last results drain
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/upq_pkg.sv
hdl/upq_if.sv
hdl/upq_ram.sv
hdl/upq_ctrl.sv
hdl/unsorted_priority_queue_core.sv
tb/upq_result_checker.sv
tb/tb.sv
